// ===== src/dngr_pkg.sv =====
// Package for the decimal number glyph renderer: job type, widths, font ROM,
// powers of ten. No dependencies.
package dngr_pkg;

	localparam int MAX_DIGITS_DEF = 10;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CNT_W          = 4;    // digit count, up to ten
	localparam int MAG_W          = 31;
	localparam int X_W            = 12;
	localparam int Y_W            = 11;
	localparam int COLOR_W        = 32;
	localparam int GLYPH_W        = 35;
	localparam int DIGIT_PITCH    = 12;
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;   // 2^35 / 10, rounded up
	localparam int RECIP_SHIFT    = 35;

	typedef struct packed {
		logic [MAG_W-1:0]   mag;
		logic [X_W-1:0]     x;      // column of the least significant glyph, emitted first
		logic [Y_W-1:0]     y;
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;  // digits to emit, 1..MAX_DIGITS
	} job_t;

	function automatic logic [MAG_W-1:0] pow10(input logic [CNT_W-1:0] i);
		logic [MAG_W-1:0] p;
		unique case (i)
			4'd1:    p = 31'd10;
			4'd2:    p = 31'd100;
			4'd3:    p = 31'd1000;
			4'd4:    p = 31'd10000;
			4'd5:    p = 31'd100000;
			4'd6:    p = 31'd1000000;
			4'd7:    p = 31'd10000000;
			4'd8:    p = 31'd100000000;
			4'd9:    p = 31'd1000000000;
			default: p = '1;
		endcase
		return p;
	endfunction

	// 5x7 font, row 0 in the top five bits
	function automatic logic [GLYPH_W-1:0] glyph_of(input logic [3:0] d);
		logic [GLYPH_W-1:0] g;
		unique case (d)
			4'd0:    g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			4'd1:    g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			4'd2:    g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
			4'd3:    g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
			4'd4:    g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
			4'd5:    g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h11, 5'h0E};
			4'd6:    g = {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
			4'd7:    g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
			4'd8:    g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
			4'd9:    g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== src/decimal_number_glyph_renderer.sv =====
// Top level of the decimal number glyph renderer: front end, job queue,
// back end. Depends on dngr_pkg, dngr_front, dngr_queue, dngr_back.
//
// Takes a signed number with a screen position and a color and produces one
// glyph transfer per decimal digit, least significant digit first, each with
// its left column (pos_x plus 12 per place from the leftmost digit), row,
// digit, 5x7 bitmap and color; last_digit marks the most significant digit.
// Zero gives one glyph; a negative number is taken and gives nothing; numbers
// with more than MAX_DIGITS digits show only their low MAX_DIGITS digits.
// Timing: the front end counts digits and places the number in the cycle it
// is taken and writes a two-entry job queue, so push is refused only while
// that queue is full. The back end loads a job and then emits one digit per
// cycle through its divide-by-ten unit (a reciprocal multiply) while pop keeps
// up with the output register; it loads the next job only after the last
// digit of the current one. Results sit in a one-entry output register; the
// oldest is on the ports whenever empty is low.
module decimal_number_glyph_renderer #(
	parameter int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [31:0]  value,
	input  logic [10:0]  pos_x,
	input  logic [10:0]  pos_y,
	input  logic [31:0]  paint,
	output logic         empty,
	input  logic         pop,
	output logic [11:0]  digit_x,
	output logic [10:0]  digit_y,
	output logic [3:0]   digit_value,
	output logic [34:0]  glyph_bits,
	output logic [31:0]  pixel_color,
	output logic         last_digit
);

	dngr_pkg::job_t q_wdata, q_rdata;
	logic           q_wr, q_rd, q_full, q_empty;

	// full tracks the queue; negatives are taken and dropped here
	assign full = q_full;

	dngr_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.push    (push),
		.q_full  (q_full),
		.value   (value),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.paint   (paint),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	dngr_queue #(
		.WIDTH ($bits(dngr_pkg::job_t)),
		.DEPTH (dngr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	dngr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.digit_x     (digit_x),
		.digit_y     (digit_y),
		.digit_value (digit_value),
		.glyph_bits  (glyph_bits),
		.pixel_color (pixel_color),
		.last_digit  (last_digit)
	);

endmodule

// ===== src/dngr_front.sv =====
// Front end: takes numbers, drops negatives, counts digits and places the
// first (rightmost) glyph. Depends on dngr_pkg.
module dngr_front #(
	parameter int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF
) (
	input  logic                        push,
	input  logic                        q_full,
	input  logic [31:0]                 value,
	input  logic [10:0]                 pos_x,
	input  logic [10:0]                 pos_y,
	input  logic [31:0]                 paint,
	output logic                        q_wr,
	output dngr_pkg::job_t              q_wdata
);

	logic [dngr_pkg::CNT_W-1:0] cnt;
	logic [dngr_pkg::CNT_W-1:0] cm1;
	logic [dngr_pkg::X_W-1:0]   span;

	// digit count = 1 + number of powers of ten not above the value, capped
	always_comb begin
		cnt = dngr_pkg::CNT_W'(1);
		for (int i = 1; i < 10; i++) begin
			if (i < MAX_DIGITS && value[30:0] >= dngr_pkg::pow10(dngr_pkg::CNT_W'(i)))
				cnt = cnt + dngr_pkg::CNT_W'(1);
		end
	end

	assign cm1  = cnt - dngr_pkg::CNT_W'(1);
	assign span = (dngr_pkg::X_W'(cm1) << 3) + (dngr_pkg::X_W'(cm1) << 2);

	assign q_wr          = push && !q_full && !value[31];
	assign q_wdata.mag   = value[30:0];
	assign q_wdata.x     = dngr_pkg::X_W'({1'b0, pos_x}) + span;
	assign q_wdata.y     = pos_y;
	assign q_wdata.color = paint;
	assign q_wdata.count = cnt;

endmodule

// ===== src/dngr_queue.sv =====
// Small register queue between front and back end.
// Depends on nothing.
module dngr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			if (rd)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			if (wr && !rd)
				count_q <= count_q + CNT_W'(1);
			else if (rd && !wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd |-> !wr) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd) else $error("queue read while empty");
`endif

endmodule

// ===== src/dngr_back.sv =====
// Back end: divides by ten once per cycle while the output register is free or
// popped, emitting one glyph per digit into it. Depends on dngr_pkg.
module dngr_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  dngr_pkg::job_t                     q_rdata,
	output logic                               q_rd,
	output logic                               empty,
	input  logic                               pop,
	output logic [dngr_pkg::X_W-1:0]           digit_x,
	output logic [dngr_pkg::Y_W-1:0]           digit_y,
	output logic [3:0]                         digit_value,
	output logic [dngr_pkg::GLYPH_W-1:0]       glyph_bits,
	output logic [dngr_pkg::COLOR_W-1:0]       pixel_color,
	output logic                               last_digit
);

	logic                           busy_q;
	logic [dngr_pkg::MAG_W-1:0]     rem_q;
	logic [dngr_pkg::X_W-1:0]       x_q;
	logic [dngr_pkg::Y_W-1:0]       y_q;
	logic [dngr_pkg::COLOR_W-1:0]   color_q;
	logic [dngr_pkg::CNT_W-1:0]     left_q;

	logic                           out_valid_q;
	logic [dngr_pkg::X_W-1:0]       out_x_q;
	logic [dngr_pkg::Y_W-1:0]       out_y_q;
	logic [3:0]                     out_d_q;
	logic [dngr_pkg::GLYPH_W-1:0]   out_g_q;
	logic [dngr_pkg::COLOR_W-1:0]   out_c_q;
	logic                           out_last_q;

	logic [62:0]                    prod;
	logic [dngr_pkg::MAG_W-1:0]     quo;
	logic [dngr_pkg::MAG_W-1:0]     rmd;
	logic [3:0]                     dig;
	logic                           emit;
	logic                           fin;

	// quotient by reciprocal multiply, remainder by shift-add
	assign prod = 63'(rem_q) * 63'(dngr_pkg::RECIP_TEN);
	assign quo  = dngr_pkg::MAG_W'(prod >> dngr_pkg::RECIP_SHIFT);
	assign rmd  = rem_q - (quo << 3) - (quo << 1);
	assign dig  = rmd[3:0];

	assign emit = busy_q && (!out_valid_q || pop);
	assign fin  = emit && (left_q == dngr_pkg::CNT_W'(1));
	assign q_rd = !busy_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd)
				busy_q <= 1'b1;
			else if (fin)
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			rem_q   <= q_rdata.mag;
			x_q     <= q_rdata.x;
			y_q     <= q_rdata.y;
			color_q <= q_rdata.color;
			left_q  <= q_rdata.count;
		end else if (emit) begin
			rem_q  <= quo;
			x_q    <= x_q - dngr_pkg::X_W'(dngr_pkg::DIGIT_PITCH);
			left_q <= left_q - dngr_pkg::CNT_W'(1);
		end
		if (emit) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_d_q    <= dig;
			out_g_q    <= dngr_pkg::glyph_of(dig);
			out_c_q    <= color_q;
			out_last_q <= (left_q == dngr_pkg::CNT_W'(1));
		end
	end

	assign empty       = !out_valid_q;
	assign digit_x     = out_x_q;
	assign digit_y     = out_y_q;
	assign digit_value = out_d_q;
	assign glyph_bits  = out_g_q;
	assign pixel_color = out_c_q;
	assign last_digit  = out_last_q;

`ifndef SYNTHESIS
	a_busy_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != '0) else $error("busy with no digits left");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> dig <= 4'd9) else $error("digit out of range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for decimal_number_glyph_renderer: directed and random numbers,
// with an in-bench digit/glyph predictor and a checker on every result transfer.
// Depends on dngr_pkg and the RTL under src/.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int X_W     = dngr_pkg::X_W;
	localparam int Y_W     = dngr_pkg::Y_W;
	localparam int COLOR_W = dngr_pkg::COLOR_W;
	localparam int GLYPH_W = dngr_pkg::GLYPH_W;

	localparam int PITCH      = 12;     // columns between neighboring glyphs
	localparam int DIGITS_CAP = 10;     // most digits shown per number
	localparam int RAND_ITEMS = 280;    // random numbers, negatives included
	localparam int STALL_CAP  = 1500;   // cycles without any transfer before giving up
	localparam int TAIL       = 40;     // quiet cycles after the last result

	// one number to render, as presented on the input side
	typedef struct {
		logic [31:0]        value;
		logic [10:0]        x;
		logic [10:0]        y;
		logic [COLOR_W-1:0] color;
		bit                 drain;  // hold off until every glyph due has arrived
	} number_t;

	// one glyph as it should leave the block
	typedef struct {
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [3:0]         digit;
		logic [GLYPH_W-1:0] bits;
		logic [COLOR_W-1:0] color;
		logic               last;
	} glyph_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// every input starts known
	logic               push = 1'b0;
	logic [31:0]        value = '0;
	logic [10:0]        pos_x = '0;
	logic [10:0]        pos_y = '0;
	logic [31:0]        paint = '0;
	logic               pop = 1'b0;

	logic               full;
	logic               empty;
	logic [11:0]        digit_x;
	logic [10:0]        digit_y;
	logic [3:0]         digit_value;
	logic [34:0]        glyph_bits;
	logic [31:0]        pixel_color;
	logic               last_digit;

	number_t numbers_pending[$];    // filled by the stimulus block, drained by the driver
	glyph_t  glyphs_due[$];         // predicted glyphs, oldest first
	number_t on_port;               // number currently offered on the input side
	int      fail_cnt = 0;
	int      push_wait = 0;
	int      pop_wait = 0;
	int      push_calm = 0;
	int      pop_calm = 0;
	int      quiet_cycles = 0;
	logic    push_nxt;

	decimal_number_glyph_renderer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.paint      (paint),
		.empty      (empty),
		.pop        (pop),
		.digit_x    (digit_x),
		.digit_y    (digit_y),
		.digit_value(digit_value),
		.glyph_bits (glyph_bits),
		.pixel_color(pixel_color),
		.last_digit (last_digit)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// 5x7 font, seven rows of five bits, top row first, left column as row MSB
	function automatic logic [GLYPH_W-1:0] font_bitmap(input logic [3:0] d);
		logic [4:0] rows [7];
		logic [GLYPH_W-1:0] acc;
		case (d)
			4'd0: rows = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			4'd1: rows = '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			4'd2: rows = '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
			4'd3: rows = '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
			4'd4: rows = '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
			4'd5: rows = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h11, 5'h0E};
			4'd6: rows = '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
			4'd7: rows = '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
			4'd8: rows = '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
			4'd9: rows = '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
			default: rows = '{default: 5'h00};
		endcase
		acc = '0;
		for (int r = 0; r < 7; r++)
			acc = {acc[GLYPH_W-6:0], rows[r]};
		return acc;
	endfunction

	// Expected glyphs for one accepted number. Negative numbers are swallowed.
	// The low-order digit comes out first, at the rightmost column; columns step
	// left by the pitch and the most significant shown digit carries the last flag.
	task automatic expand_digits(input number_t n);
		int unsigned    rest;
		int             ndig;
		logic [X_W-1:0] col;
		glyph_t         g;
		if (n.value[31])
			return;
		rest = n.value;
		ndig = 0;
		do begin
			ndig++;
			rest = rest / 10;
		end while (rest != 0 && ndig < DIGITS_CAP);
		col = X_W'(n.x + (ndig - 1) * PITCH);
		rest = {1'b0, n.value[30:0]};
		for (int k = 0; k < ndig; k++) begin
			g.x     = col;
			g.y     = n.y;
			g.digit = 4'(rest % 10);
			g.bits  = font_bitmap(g.digit);
			g.color = n.color;
			g.last  = (k == ndig - 1);
			glyphs_due.push_back(g);
			rest = rest / 10;
			col  = col - X_W'(PITCH);
		end
	endtask

	// Idle length for either side: mostly none or short, a few long ones, and now
	// and then a calm stretch with no idling at all.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(15, 50);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic number_t mk_number(input logic [31:0] v, input logic [10:0] x,
			input logic [10:0] y, input logic [31:0] c, input bit drain);
		number_t n;
		n.value = v;
		n.x     = x;
		n.y     = y;
		n.color = c;
		n.drain = drain;
		return n;
	endfunction

	// Random number with a uniformly chosen digit count, so long and short
	// numbers are equally common; some zeros, negatives and raw 32-bit noise.
	function automatic logic [31:0] rand_value();
		int          r;
		int          ndig;
		longint      lo;
		longint      hi;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom | 32'h8000_0000;
		if (r < 12)
			return $urandom;
		if (r < 16)
			return 32'd0;
		ndig = $urandom_range(1, DIGITS_CAP);
		lo = 1;
		for (int i = 1; i < ndig; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (hi > 64'd2147483647)
			hi = 64'd2147483647;
		if (ndig == 1)
			lo = 0;
		return 32'(lo + longint'($urandom) % (hi - lo + 1));
	endfunction

	// Driver: presents numbers from the pending queue. An offered number is
	// transferred at the edge where push is high and full is low; the predictor
	// runs on exactly that number. push gets a single nonblocking update per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			push_wait = 0;
		end else begin
			push_nxt = push;
			if (push && !full) begin
				expand_digits(on_port);
				push_nxt = 1'b0;
			end
			if (!push_nxt) begin
				if (push_wait > 0) begin
					push_wait--;
				end else if (numbers_pending.size() != 0 &&
						!(numbers_pending[0].drain && glyphs_due.size() != 0)) begin
					on_port = numbers_pending.pop_front();
					value <= on_port.value;
					pos_x <= on_port.x;
					pos_y <= on_port.y;
					paint <= on_port.color;
					push_nxt = 1'b1;
					push_wait = idle_len(push_calm);
				end
			end
			push <= push_nxt;
		end
	end

	// Monitor: checks each result transfer against the oldest prediction, then
	// picks the pop level for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait = 0;
		end else begin
			if (pop && !empty) begin
				if (glyphs_due.size() == 0) begin
					$error("glyph transfer with nothing due: digit_value %0d", digit_value);
					fail_cnt++;
				end else begin
					glyph_t g;
					g = glyphs_due.pop_front();
					if (digit_x !== g.x) begin
						$error("digit_x: expected %0d, got %0d", g.x, digit_x);
						fail_cnt++;
					end
					if (digit_y !== g.y) begin
						$error("digit_y: expected %0d, got %0d", g.y, digit_y);
						fail_cnt++;
					end
					if (digit_value !== g.digit) begin
						$error("digit_value: expected %0d, got %0d", g.digit, digit_value);
						fail_cnt++;
					end
					if (glyph_bits !== g.bits) begin
						$error("glyph_bits: expected %h, got %h", g.bits, glyph_bits);
						fail_cnt++;
					end
					if (pixel_color !== g.color) begin
						$error("pixel_color: expected %h, got %h", g.color, pixel_color);
						fail_cnt++;
					end
					if (last_digit !== g.last) begin
						$error("last_digit: expected %0b, got %0b", g.last, last_digit);
						fail_cnt++;
					end
				end
			end
			if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				pop_wait = idle_len(pop_calm);
			end
		end
	end

	// Watchdog: a long run of cycles with no transfer on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_CAP) begin
				$display("** decimal_number_glyph_renderer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int kept;
		number_t n;

		// directed: zero, single digits, digit-count boundaries, the largest
		// positive value, every digit glyph, negatives, field extremes
		numbers_pending.push_back(mk_number(32'd0, 11'd0, 11'd0, 32'h0, 1'b0));
		numbers_pending.push_back(mk_number(32'd1, 11'd2047, 11'd2047, 32'hFFFF_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'd9, 11'd5, 11'd7, 32'h1234_5678, 1'b0));
		numbers_pending.push_back(mk_number(32'd10, 11'd100, 11'd200, 32'hA5A5_A5A5, 1'b0));
		numbers_pending.push_back(mk_number(32'd99, 11'd0, 11'd2047, 32'h5A5A_5A5A, 1'b0));
		numbers_pending.push_back(mk_number(32'd100, 11'd2047, 11'd0, 32'hFFFF_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'd1234567890, 11'd2047, 11'd1024,
			32'hDEAD_BEEF, 1'b0));
		numbers_pending.push_back(mk_number(32'd987654321, 11'd1, 11'd1, 32'h0000_0001, 1'b0));
		// sender waits here for the block to drain before going on
		numbers_pending.push_back(mk_number(32'd2147483647, 11'd2047, 11'd2047,
			32'h8000_0000, 1'b1));
		numbers_pending.push_back(mk_number(32'd1000000000, 11'd0, 11'd0, 32'h7FFF_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'd999999999, 11'd1023, 11'd511, 32'h0, 1'b0));
		numbers_pending.push_back(mk_number(32'hFFFF_FFFF, 11'd2047, 11'd2047,
			32'hFFFF_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'h8000_0000, 11'd0, 11'd0, 32'h0, 1'b0));
		numbers_pending.push_back(mk_number(32'd0, 11'd2047, 11'd2047, 32'hFFFF_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'd1000000001, 11'd2047, 11'd2047,
			32'h0F0F_0F0F, 1'b0));
		numbers_pending.push_back(mk_number(32'hFFFF_FFF6, 11'd3, 11'd3, 32'h1, 1'b0));
		numbers_pending.push_back(mk_number(32'd5, 11'd2047, 11'd0, 32'hF0F0_F0F0, 1'b1));
		numbers_pending.push_back(mk_number(32'd46, 11'd12, 11'd12, 32'h0000_FFFF, 1'b0));
		numbers_pending.push_back(mk_number(32'd73, 11'd24, 11'd36, 32'hFFFF_0000, 1'b0));

		// random: now and then the sender holds off until every glyph due
		// has come out
		kept = 0;
		while (kept < RAND_ITEMS) begin
			n = mk_number(rand_value(), 11'($urandom), 11'($urandom), $urandom,
				$urandom_range(0, 39) == 0);
			kept++;
			numbers_pending.push_back(n);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_pending.size() != 0 || push)
			@(posedge clk);
		while (glyphs_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (fail_cnt == 0 && glyphs_due.size() == 0)
			$display("** decimal_number_glyph_renderer: PASSED **");
		else
			$display("** decimal_number_glyph_renderer: FAILED **");
		$finish;
	end

endmodule
